FILE: rtl/core/pdpg_pkg.sv
`default_nettype none
package pdpg_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam int TRIG_W = 34;
    localparam int ANG_W = 33;
    localparam logic signed [TRIG_W-1:0] INV_GAIN_Q30 = 34'sd652032874;

    typedef enum logic [2:0] {
        CFG_CENTER_X = 3'd0,
        CFG_CENTER_Y = 3'd1,
        CFG_CENTER_Z = 3'd2,
        CFG_RADIUS   = 3'd3,
        CFG_PLANE    = 3'd4
    } pdpg_cfg_index_t;

    typedef enum logic [1:0] {
        PLANE_XY = 2'd0,
        PLANE_XZ = 2'd1,
        PLANE_YZ = 2'd2
    } pdpg_plane_t;

    typedef struct packed {
        logic [15:0] angle;
        logic [15:0] radial_fraction;
        logic [18:0] angle_width;
        logic [15:0] radial_width;
    } pdpg_in_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [62:0]        area_element;
    } pdpg_out_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  quadrant;
        logic [31:0] scaled_radius;
    } pdpg_side_t;

    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pdpg_delay.sv
`default_nettype none
module pdpg_delay #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic [WIDTH-1:0] din,
    output logic      [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] stage_reg [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_tap
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    stage_reg[i] <= '0;
                end
                else if (en)
                begin
                    if (i == 0)
                    begin
                        stage_reg[i] <= din;
                    end
                    else
                    begin
                        stage_reg[i] <= stage_reg[(i == 0) ? 0 : i-1];
                    end
                end
            end
        end
    endgenerate

    assign dout = stage_reg[DEPTH-1];

endmodule
`default_nettype wire

FILE: rtl/core/pdpg_cordic.sv
`default_nettype none
module pdpg_cordic
    import pdpg_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [ANG_W-1:0]  z_in,
    output logic signed      [TRIG_W-1:0] x_out,
    output logic signed      [TRIG_W-1:0] y_out
);

    logic signed [TRIG_W-1:0] x_reg [STAGES];
    logic signed [TRIG_W-1:0] y_reg [STAGES];
    logic signed [ANG_W-1:0]  z_reg [STAGES];

    genvar i;
    generate
        for (i = 0; i < STAGES; i++) begin : g_stage
            logic signed [TRIG_W-1:0] x_prev;
            logic signed [TRIG_W-1:0] y_prev;
            logic signed [ANG_W-1:0]  z_prev;
            logic signed [TRIG_W-1:0] x_next;
            logic signed [TRIG_W-1:0] y_next;
            logic signed [ANG_W-1:0]  z_next;
            logic signed [ANG_W-1:0]  step;

            if (i == 0)
            begin : g_first
                assign x_prev = INV_GAIN_Q30;
                assign y_prev = '0;
                assign z_prev = z_in;
            end
            else
            begin : g_rest
                assign x_prev = x_reg[i-1];
                assign y_prev = y_reg[i-1];
                assign z_prev = z_reg[i-1];
            end

            assign step = $signed({1'b0, atan_turn(i)});

            always_comb
            begin
                if (!z_prev[ANG_W-1])
                begin
                    x_next = x_prev - (y_prev >>> i);
                    y_next = y_prev + (x_prev >>> i);
                    z_next = z_prev - step;
                end
                else
                begin
                    x_next = x_prev + (y_prev >>> i);
                    y_next = y_prev - (x_prev >>> i);
                    z_next = z_prev + step;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[i] <= x_next;
                    y_reg[i] <= y_next;
                    z_reg[i] <= z_next;
                end
            end
        end
    endgenerate

    assign x_out = x_reg[STAGES-1];
    assign y_out = y_reg[STAGES-1];

endmodule
`default_nettype wire

FILE: rtl/core/pdpg_area.sv
`default_nettype none
module pdpg_area (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [15:0] s,
    input  wire logic [15:0] ds,
    input  wire logic [18:0] dth,
    input  wire logic [30:0] radius,
    output logic      [62:0] area
);

    logic [31:0]  a_reg;
    logic [61:0]  r2_reg;
    logic [18:0]  dth_reg;
    logic [50:0]  b_reg;
    logic [61:0]  r2b_reg;
    logic [62:0]  p00_reg;
    logic [62:0]  p01_reg;
    logic [49:0]  p10_reg;
    logic [49:0]  p11_reg;
    logic [62:0]  area_reg;
    logic [112:0] sum;

    always_comb
    begin
        sum = {50'd0, p00_reg}
            + ({50'd0, p01_reg} << 31)
            + ({63'd0, p10_reg} << 32)
            + ({63'd0, p11_reg} << 63);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= 32'(s * ds);
            r2_reg  <= 62'(radius * radius);
            dth_reg <= dth;
            b_reg   <= 51'(a_reg * dth_reg);
            r2b_reg <= r2_reg;
            p00_reg <= 63'(b_reg[31:0] * r2b_reg[30:0]);
            p01_reg <= 63'(b_reg[31:0] * r2b_reg[61:31]);
            p10_reg <= 50'(b_reg[50:32] * r2b_reg[30:0]);
            p11_reg <= 50'(b_reg[50:32] * r2b_reg[61:31]);
            if (sum[112:109] != 4'd0)
            begin
                area_reg <= {63{1'b1}};
            end
            else
            begin
                area_reg <= sum[108:46];
            end
        end
    end

    assign area = area_reg;

endmodule
`default_nettype wire

FILE: rtl/core/planar_disk_point_generator.sv
`default_nettype none
// channel   dir  handshake              payload
// input     in   in_valid / in_ready    in_data   (pdpg_in_t)
// output    out  out_valid / out_ready  out_data  (pdpg_out_t)
// config    in   cfg_we                 cfg_index, cfg_data
//
// One request per cycle unless the output stalls; each request passes
// the input, CORDIC rotation, quadrant, multiply and output stages.
// rst_n clears the configuration registers and all valid bits.
// A stalled output freezes the whole pipeline; in_ready is low only then.
module planar_disk_point_generator
    import pdpg_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire pdpg_in_t    in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output pdpg_out_t        out_data,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic signed [31:0] center_z_reg;
    logic [30:0]        radius_reg;
    logic [1:0]         plane_reg;

    logic en;

    logic [31:0]             phase;
    logic [31:0]             phase_bias;
    logic [1:0]              quadrant_next;
    logic [31:0]             resid;
    logic [31:0]             rs_next;

    logic                    r0_valid_reg;
    logic signed [ANG_W-1:0] r0_z_reg;
    logic [1:0]              r0_q_reg;
    logic [31:0]             r0_rs_reg;
    logic [15:0]             r0_s_reg;
    logic [15:0]             r0_ds_reg;
    logic [18:0]             r0_dth_reg;

    logic signed [TRIG_W-1:0] cx;
    logic signed [TRIG_W-1:0] cy;
    pdpg_side_t               side_in;
    pdpg_side_t               side_out;

    logic                     rot_valid_reg;
    logic signed [TRIG_W-1:0] rot_c_reg;
    logic signed [TRIG_W-1:0] rot_s_reg;
    logic [31:0]              rot_rs_reg;
    logic signed [TRIG_W-1:0] rot_c_next;
    logic signed [TRIG_W-1:0] rot_s_next;

    logic              mul_valid_reg;
    logic [64:0]       mul_c_reg;
    logic [64:0]       mul_s_reg;
    logic              mul_cneg_reg;
    logic              mul_sneg_reg;
    logic [TRIG_W-2:0] mag_c;
    logic [TRIG_W-2:0] mag_s;

    logic [62:0] area_raw;
    logic [62:0] area_aligned;

    logic signed [66:0] dc_full;
    logic signed [66:0] ds_full;
    logic signed [36:0] dc;
    logic signed [36:0] dsn;
    logic signed [31:0] px_next;
    logic signed [31:0] py_next;
    logic signed [31:0] pz_next;

    logic      out_valid_reg;
    pdpg_out_t out_data_reg;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] c,
                                                   input logic signed [36:0] d);
        logic signed [37:0] t;
        t = 38'(c) + 38'(d);
        if (t > 38'sd2147483647)
        begin
            return 32'sh7FFFFFFF;
        end
        if (t < -38'sd2147483648)
        begin
            return 32'sh80000000;
        end
        return t[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= '0;
            plane_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CENTER_X: center_x_reg <= cfg_data;
                CFG_CENTER_Y: center_y_reg <= cfg_data;
                CFG_CENTER_Z: center_z_reg <= cfg_data;
                CFG_RADIUS:   radius_reg   <= cfg_data[30:0];
                CFG_PLANE:    plane_reg    <= cfg_data[1:0];
                default:      ;
            endcase
        end
    end

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    always_comb
    begin
        phase         = {in_data.angle, 16'd0};
        phase_bias    = phase + 32'h2000_0000;
        quadrant_next = phase_bias[31:30];
        resid         = phase - {quadrant_next, 30'd0};
        rs_next       = 32'((48'(in_data.radial_fraction) * 48'(radius_reg)) >> 15);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            r0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_z_reg   <= $signed({resid[31], resid});
            r0_q_reg   <= quadrant_next;
            r0_rs_reg  <= rs_next;
            r0_s_reg   <= in_data.radial_fraction;
            r0_ds_reg  <= in_data.radial_width;
            r0_dth_reg <= in_data.angle_width;
        end
    end

    pdpg_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk   (clk),
        .en    (en),
        .z_in  (r0_z_reg),
        .x_out (cx),
        .y_out (cy)
    );

    assign side_in = '{valid: r0_valid_reg, quadrant: r0_q_reg, scaled_radius: r0_rs_reg};

    pdpg_delay #(
        .DEPTH (CORDIC_STAGES),
        .WIDTH ($bits(pdpg_side_t))
    ) u_side (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (side_in),
        .dout  (side_out)
    );

    pdpg_area u_area (
        .clk    (clk),
        .en     (en),
        .s      (r0_s_reg),
        .ds     (r0_ds_reg),
        .dth    (r0_dth_reg),
        .radius (radius_reg),
        .area   (area_raw)
    );

    pdpg_delay #(
        .DEPTH (CORDIC_STAGES - 2),
        .WIDTH (63)
    ) u_area_align (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (area_raw),
        .dout  (area_aligned)
    );

    always_comb
    begin
        case (side_out.quadrant)
            2'd0:
            begin
                rot_c_next = cx;
                rot_s_next = cy;
            end
            2'd1:
            begin
                rot_c_next = -cy;
                rot_s_next = cx;
            end
            2'd2:
            begin
                rot_c_next = -cx;
                rot_s_next = -cy;
            end
            default:
            begin
                rot_c_next = cy;
                rot_s_next = -cx;
            end
        endcase
    end

    always_comb
    begin
        mag_c = rot_c_reg[TRIG_W-1] ? (TRIG_W-1)'(-rot_c_reg) : rot_c_reg[TRIG_W-2:0];
        mag_s = rot_s_reg[TRIG_W-1] ? (TRIG_W-1)'(-rot_s_reg) : rot_s_reg[TRIG_W-2:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_valid_reg <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rot_valid_reg <= side_out.valid;
            mul_valid_reg <= rot_valid_reg;
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_c_reg    <= rot_c_next;
            rot_s_reg    <= rot_s_next;
            rot_rs_reg   <= side_out.scaled_radius;
            mul_c_reg    <= 65'(rot_rs_reg * mag_c);
            mul_s_reg    <= 65'(rot_rs_reg * mag_s);
            mul_cneg_reg <= rot_c_reg[TRIG_W-1];
            mul_sneg_reg <= rot_s_reg[TRIG_W-1];
        end
    end

    always_comb
    begin
        dc_full = mul_cneg_reg ? -$signed({2'b00, mul_c_reg}) : $signed({2'b00, mul_c_reg});
        ds_full = mul_sneg_reg ? -$signed({2'b00, mul_s_reg}) : $signed({2'b00, mul_s_reg});
        dc_full = dc_full + 67'sd536870912;
        ds_full = ds_full + 67'sd536870912;
        dc      = 37'(dc_full >>> 30);
        dsn     = 37'(ds_full >>> 30);
        px_next = center_x_reg;
        py_next = center_y_reg;
        pz_next = center_z_reg;
        case (plane_reg)
            PLANE_XZ:
            begin
                px_next = sat_add(center_x_reg, dc);
                pz_next = sat_add(center_z_reg, dsn);
            end
            PLANE_YZ:
            begin
                py_next = sat_add(center_y_reg, dc);
                pz_next = sat_add(center_z_reg, dsn);
            end
            default:
            begin
                px_next = sat_add(center_x_reg, dc);
                py_next = sat_add(center_y_reg, dsn);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg.pos_x        <= px_next;
            out_data_reg.pos_y        <= py_next;
            out_data_reg.pos_z        <= pz_next;
            out_data_reg.area_element <= area_aligned;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

    a_mul_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_valid_reg && !en) |=> mul_valid_reg)
        else $error("pipeline lost a request during stall");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_ready) |-> (out_valid && !out_ready))
        else $error("input blocked without output stall");

endmodule
`default_nettype wire
